// File: sv/wcmu_pkg.sv
// Package for the word clock grid update block: sizes, grid letter tables
// and the per-row grid builder. No dependencies.
package wcmu_pkg;

	localparam int ROWS = 10;
	localparam int COLS = 11;
	localparam int ROW_W = 4;
	localparam int IDX_W = 4;    // five-minute slot 0..11, also hour 0..11
	localparam int HOUR_W = 5;
	localparam int MIN_W = 6;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 32;

	localparam logic [COLS-1:0] BANNER_ROW0 = 11'h7E0;
	localparam logic [COLS-1:0] ALL_COLS = 11'h7FF;
	localparam logic [COLS-1:0] IT_IS_BITS = 11'h01B;
	localparam logic [COLS-1:0] PAST_BITS = 11'h00F;
	localparam logic [COLS-1:0] TO_BITS = 11'h600;
	localparam logic [ROW_W-1:0] IT_IS_ROW = 4'd0;
	localparam logic [ROW_W-1:0] TO_ROW = 4'd3;
	localparam logic [ROW_W-1:0] PAST_ROW = 4'd4;
	localparam logic [IDX_W-1:0] FIRST_TO_SLOT = 4'd7;

	typedef struct packed {
		logic capture;   // request accepted this cycle
		logic start;     // build pending-row mask
		logic step;      // handle the current row
	} wcmu_cmd_t;

	typedef struct packed {
		logic skip;        // accepted tick would not change the minute
		logic pend_empty;  // no rows left to send
		logic stall;       // current row must go out but the output is full
	} wcmu_sts_t;

	function automatic logic [ROW_W-1:0] hour_row(input logic [IDX_W-1:0] hr);
		logic [ROW_W-1:0] r;
		case (hr)
			4'd0: r = 4'd8;
			4'd1: r = 4'd5;
			4'd2: r = 4'd6;
			4'd3: r = 4'd5;
			4'd4: r = 4'd6;
			4'd5: r = 4'd6;
			4'd6: r = 4'd5;
			4'd7: r = 4'd8;
			4'd8: r = 4'd7;
			4'd9: r = 4'd4;
			4'd10: r = 4'd9;
			4'd11: r = 4'd7;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [COLS-1:0] hour_bits(input logic [IDX_W-1:0] hr);
		logic [COLS-1:0] b;
		case (hr)
			4'd0: b = 11'h7E0;
			4'd1: b = 11'h007;
			4'd2: b = 11'h700;
			4'd3: b = 11'h7C0;
			4'd4: b = 11'h00F;
			4'd5: b = 11'h0F0;
			4'd6: b = 11'h038;
			4'd7: b = 11'h01F;
			4'd8: b = 11'h01F;
			4'd9: b = 11'h780;
			4'd10: b = 11'h007;
			4'd11: b = 11'h7E0;
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [ROW_W-1:0] min_row(input logic [IDX_W-1:0] q);
		logic [ROW_W-1:0] r;
		case (q)
			4'd0: r = 4'd9;
			4'd1, 4'd4, 4'd5, 4'd7, 4'd8, 4'd11: r = 4'd2;
			4'd2, 4'd6, 4'd10: r = 4'd3;
			4'd3, 4'd9: r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [COLS-1:0] min_bits(input logic [IDX_W-1:0] q);
		logic [COLS-1:0] b;
		case (q)
			4'd0: b = 11'h7E0;
			4'd1, 4'd11: b = 11'h3C0;
			4'd2, 4'd10: b = 11'h0E0;
			4'd3, 4'd9: b = 11'h1FC;
			4'd4, 4'd8: b = 11'h03F;
			4'd5, 4'd7: b = 11'h3FF;
			4'd6: b = 11'h00F;
			default: b = '0;
		endcase
		return b;
	endfunction

	// New letters of row r; hr already carries the advance for TO.
	function automatic logic [COLS-1:0] grid_row(input logic redraw,
			input logic [IDX_W-1:0] q, input logic [IDX_W-1:0] hr,
			input logic [ROW_W-1:0] r);
		logic [COLS-1:0] b;
		b = '0;
		if (redraw) begin
			if (r == IT_IS_ROW)
				b = BANNER_ROW0;
		end else begin
			if (min_row(q) == r)
				b = b | min_bits(q);
			if (q != '0 && r == IT_IS_ROW)
				b = b | IT_IS_BITS;
			if (q != '0 && q < FIRST_TO_SLOT && r == PAST_ROW)
				b = b | PAST_BITS;
			if (q >= FIRST_TO_SLOT && r == TO_ROW)
				b = b | TO_BITS;
			if (hour_row(hr) == r)
				b = b | hour_bits(hr);
		end
		return b;
	endfunction

endpackage

// File: sv/wcmu_ctrl.sv
// Controller of the word clock grid update: takes requests and sequences
// the datapath over load and row scan. Uses wcmu_pkg.
module wcmu_ctrl
	import wcmu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  wcmu_sts_t sts,
	output wcmu_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid && !sts.skip)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.start = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.pend_empty)
					state_d = ST_IDLE;
				else
					cmd.step = !sts.stall;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: sv/wcmu_dp.sv
// Datapath of the word clock grid update: minute rounding, hour select,
// shown grid, pending-row mask and output register. Uses wcmu_pkg.
module wcmu_dp
	import wcmu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  wcmu_cmd_t             cmd,
	output wcmu_sts_t             sts,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,
	output logic                  m_tlast
);

	logic [HOUR_W-1:0] in_hour;
	logic [MIN_W-1:0]  in_min;
	logic [MIN_W:0]    min_plus;
	logic [MIN_W-1:0]  min_wrap;
	logic [9:0]        slot_prod;
	logic [IDX_W-1:0]  slot;
	logic              hour_carry;
	logic              slot_to;
	logic [HOUR_W:0]   hour_sum;
	logic [HOUR_W:0]   hour_m24;
	logic [HOUR_W:0]   hour_m12;

	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  hr_q;
	logic              redraw_q;
	logic [IDX_W-1:0]  last_slot_q;
	logic              min_valid_q;
	logic [COLS-1:0]   shown_q [ROWS];
	logic [ROWS-1:0]   pend_q;
	logic [ROWS-1:0]   pend_new;
	logic [ROW_W-1:0]  row_q;
	logic [COLS-1:0]   cur_row;
	logic              cur_pend;
	logic              cur_last;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COLS-1:0]   out_lit_q;
	logic [COLS-1:0]   out_chg_q;
	logic              out_last_q;

	assign in_hour = s_tdata[HOUR_W-1:0];
	assign in_min = s_tdata[HOUR_W+MIN_W-1:HOUR_W];

	// Round to the nearest five: (m + 2) mod 60, then divide by 5 as *13 >> 6.
	assign min_plus = {1'b0, in_min} + 7'd2;
	assign hour_carry = (min_plus > 7'd59);
	assign min_wrap = hour_carry ? 6'(min_plus - 7'd60) : min_plus[MIN_W-1:0];
	assign slot_prod = 10'(min_wrap) * 10'd13;
	assign slot = slot_prod[9:6];
	assign slot_to = (slot >= FIRST_TO_SLOT);

	assign hour_sum = {1'b0, in_hour} + 6'(hour_carry) + 6'(slot_to);
	assign hour_m24 = (hour_sum >= 6'd24) ? hour_sum - 6'd24 : hour_sum;
	assign hour_m12 = (hour_m24 >= 6'd12) ? hour_m24 - 6'd12 : hour_m24;

	assign cur_row = grid_row(redraw_q, slot_q, hr_q, row_q);
	assign cur_pend = pend_q[row_q];
	assign cur_last = ((pend_q & ~(10'd1 << row_q)) == '0);

	always_comb begin
		for (int r = 0; r < ROWS; r++)
			pend_new[r] = redraw_q ||
				(grid_row(redraw_q, slot_q, hr_q, ROW_W'(r)) != shown_q[r]);
	end

	assign sts.skip = !s_tuser && min_valid_q && (last_slot_q == slot);
	assign sts.pend_empty = (pend_q == '0);
	assign sts.stall = cur_pend && out_valid_q && !m_tready;

	// Control and grid state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_slot_q <= '0;
			min_valid_q <= 1'b0;
			pend_q <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++)
				shown_q[r] <= (r == 0) ? BANNER_ROW0 : '0;
		end else begin
			if (cmd.capture && !sts.skip) begin
				last_slot_q <= s_tuser ? '0 : slot;
				min_valid_q <= !s_tuser;
			end
			if (cmd.start)
				pend_q <= pend_new;
			// load a new result, else hold the one not yet taken
			out_valid_q <= (cmd.step && cur_pend) || (out_valid_q && !m_tready);
			if (cmd.step) begin
				shown_q[row_q] <= cur_row;
				if (cur_pend)
					pend_q[row_q] <= 1'b0;
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= slot;
			hr_q <= hour_m12[IDX_W-1:0];
			redraw_q <= s_tuser;
		end
		if (cmd.start)
			row_q <= '0;
		if (cmd.step) begin
			row_q <= row_q + 4'd1;
			if (cur_pend) begin
				out_row_q <= row_q;
				out_lit_q <= cur_row;
				out_chg_q <= redraw_q ? ALL_COLS : (cur_row ^ shown_q[row_q]);
				out_last_q <= cur_last;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_chg_q, out_lit_q, out_row_q};
	assign m_tlast = out_last_q;

endmodule

// File: sv/word_clock_matrix_update.sv
// Top level of the word clock grid update: controller plus datapath.
// Uses wcmu_pkg, wcmu_ctrl and wcmu_dp.
//
// Requests arrive on the s_ channel: s_tuser is the command (0 = time tick,
// 1 = redraw with the banner), s_tdata carries hour and minute. Results
// leave on the m_ channel, one per grid row whose letters changed (every
// row for a redraw), in row order, with m_tlast on the final one of a request.
// A tick that rounds to the stored minute gives no result and the block is
// ready again in the next cycle. Otherwise a request passes the accept state,
// the load state that builds the pending-row mask, then the scan, one row per
// cycle while the output does not stall, up to the last changed row (at most
// ten), and then returns to idle. The first result leaves the output register
// after the load state and the first scan step.
// A single output register holds the pending result; while the receiver
// stalls, the scan holds on the next row that must go out.
// Reset shows the banner (row 0 columns 5..10) and forgets the minute.
module word_clock_matrix_update
	import wcmu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // hour_of_day[4:0], minute_of_hour[10:5]
	input  logic                s_tuser,   // cmd[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // row_index[3:0], row_lit[14:4], row_changed[25:15]
	output logic                m_tlast
);

	wcmu_cmd_t cmd;
	wcmu_sts_t sts;

	wcmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wcmu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: sv/wcmu_chk.sv
// Port-level checks for the word clock grid update, bound to the top level.
// Uses wcmu_pkg.
module wcmu_chk
	import wcmu_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	// hold a stalled result
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	ap_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd9)
		else $error("row index out of range");

	ap_chg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:15] != 11'd0 && m_tdata[31:26] == 6'd0)
		else $error("result with empty change mask or dirty padding");

	// a redraw always sends rows, so the block goes busy
	ap_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("redraw accepted without a scan");

endmodule

bind word_clock_matrix_update wcmu_chk u_wcmu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: tb/tb_word_clock_matrix_update.sv
// Testbench for word_clock_matrix_update: drives tick and redraw requests and
// checks every row update against the bench's grid model or a directed row list.
// Depends on wcmu_pkg and the word_clock_matrix_update RTL.
module tb_word_clock_matrix_update
	import wcmu_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_REDRAW = 1'b1
	} grid_cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COLS-1:0]  lit;
		logic [COLS-1:0]  chg;
	} row_word_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COLS-1:0]  lit;
		logic [COLS-1:0]  chg;
		logic             last;
	} row_update_t;

	// n_known < 0: take the rows from the grid model
	typedef struct packed {
		grid_cmd_t          cmd;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		int                 n_known;
		row_word_t [0:2]    known;
	} clock_req_t;

	localparam int RANDOM_REQS = 480;
	localparam int LONG_HOLD = 400;

	// letters per hour 0..11 and per five-minute slot 0..11
	localparam logic [0:11][ROW_W-1:0] HOUR_ROW = {4'd8, 4'd5, 4'd6, 4'd5, 4'd6, 4'd6,
		4'd5, 4'd8, 4'd7, 4'd4, 4'd9, 4'd7};
	localparam logic [0:11][COLS-1:0] HOUR_LETTERS = {11'h7E0, 11'h007, 11'h700, 11'h7C0,
		11'h00F, 11'h0F0, 11'h038, 11'h01F, 11'h01F, 11'h780, 11'h007, 11'h7E0};
	localparam logic [0:11][ROW_W-1:0] SLOT_ROW = {4'd9, 4'd2, 4'd3, 4'd1, 4'd2, 4'd2,
		4'd3, 4'd2, 4'd2, 4'd1, 4'd3, 4'd2};
	localparam logic [0:11][COLS-1:0] SLOT_LETTERS = {11'h7E0, 11'h3C0, 11'h0E0, 11'h1FC,
		11'h03F, 11'h3FF, 11'h00F, 11'h3FF, 11'h03F, 11'h1FC, 11'h0E0, 11'h3C0};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	logic [COLS-1:0] shown_grid [ROWS];
	int              shown_minute;
	bit              minute_shown;
	row_update_t     fresh_rows [$];
	row_update_t     rows_due [$];
	clock_req_t      directed [$];
	int              fail_count = 0;
	bit              hold_req = 1'b0;

	word_clock_matrix_update dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_word_clock_matrix_update NOT OK");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	function automatic void show_banner();
		for (int i = 0; i < ROWS; i++)
			shown_grid[i] = (i == 0) ? BANNER_ROW0 : '0;
		shown_minute = 0;
		minute_shown = 1'b0;
	endfunction

	// Work out the rows one request sends (all on a redraw); leaves them in fresh_rows.
	task automatic light_words(input grid_cmd_t cmd, input logic [HOUR_W-1:0] hour,
			input logic [MIN_W-1:0] minute);
		logic [COLS-1:0] grid [ROWS];
		logic [COLS-1:0] chg;
		int plus2, rounded, hr, slot, last_row;
		fresh_rows.delete();
		if (cmd == CMD_REDRAW) begin
			show_banner();
			for (int i = 0; i < ROWS; i++)
				fresh_rows.push_back('{i[ROW_W-1:0], shown_grid[i], ALL_COLS, i == ROWS - 1});
		end else begin
			plus2 = int'(minute) + 2;
			rounded = ((plus2 % 60) / 5) * 5;
			if (!(minute_shown && shown_minute == rounded)) begin
				hr = (int'(hour) + (plus2 > 59 ? 1 : 0)) % 12;
				shown_minute = rounded;
				minute_shown = 1'b1;
				slot = rounded / 5;
				for (int i = 0; i < ROWS; i++)
					grid[i] = '0;
				grid[SLOT_ROW[slot]] = grid[SLOT_ROW[slot]] | SLOT_LETTERS[slot];
				if (rounded != 0)
					grid[IT_IS_ROW] = grid[IT_IS_ROW] | IT_IS_BITS;
				if (rounded > 1 && rounded < 31)
					grid[PAST_ROW] = grid[PAST_ROW] | PAST_BITS;
				if (rounded > 31) begin
					grid[TO_ROW] = grid[TO_ROW] | TO_BITS;
					hr = (hr + 1) % 12;
				end
				grid[HOUR_ROW[hr]] = grid[HOUR_ROW[hr]] | HOUR_LETTERS[hr];
				last_row = -1;
				for (int i = 0; i < ROWS; i++)
					if (shown_grid[i] != grid[i])
						last_row = i;
				for (int i = 0; i < ROWS; i++) begin
					chg = shown_grid[i] ^ grid[i];
					if (chg != '0)
						fresh_rows.push_back('{i[ROW_W-1:0], grid[i], chg, i == last_row});
					shown_grid[i] = grid[i];
				end
			end
		end
	endtask

	// Offer one request, wait for it to be taken, then queue its row updates.
	task automatic send_request(input clock_req_t rq, input int gap);
		row_word_t w;
		s_tvalid <= 1'b1;
		s_tuser <= rq.cmd;
		s_tdata <= {5'b0, rq.minute, rq.hour};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		light_words(rq.cmd, rq.hour, rq.minute);
		if (rq.n_known >= 0) begin
			fresh_rows.delete();
			for (int i = 0; i < rq.n_known; i++) begin
				w = rq.known[i];
				fresh_rows.push_back('{w.row, w.lit, w.chg, i == rq.n_known - 1});
			end
		end
		foreach (fresh_rows[i])
			rows_due.push_back(fresh_rows[i]);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void add_row(input grid_cmd_t cmd, input int hour, input int minute,
			input int n_known = -1, input row_word_t k0 = '0, input row_word_t k1 = '0,
			input row_word_t k2 = '0);
		clock_req_t rq;
		rq.cmd = cmd;
		rq.hour = hour[HOUR_W-1:0];
		rq.minute = minute[MIN_W-1:0];
		rq.n_known = n_known;
		rq.known = {k0, k1, k2};
		directed.push_back(rq);
	endfunction

	// Receiver: check each row update, idle at random, hold off once for long.
	initial begin : receiver
		row_update_t want, got;
		int cyc, gap_left;
		bit held;
		cyc = 0;
		gap_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = '{m_tdata[3:0], m_tdata[14:4], m_tdata[25:15], m_tlast};
				if (rows_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected row update: row %0d lit %03h chg %03h last %0b",
						$time, got.row, got.lit, got.chg, got.last);
				end else begin
					want = rows_due.pop_front();
					if (got.row !== want.row || got.lit !== want.lit ||
							got.chg !== want.chg || got.last !== want.last) begin
						fail_count++;
						$display("%0t: row update mismatch: expected row %0d lit %03h chg %03h last %0b, got row %0d lit %03h chg %03h last %0b",
							$time, want.row, want.lit, want.chg, want.last,
							got.row, got.lit, got.chg, got.last);
					end
				end
			end
			cyc++;
			if (hold_req && !held) begin
				held = 1'b1;
				gap_left = LONG_HOLD;
			end
			if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				// alternate stretches with and without idling
				if ((cyc % 1024) >= 256 && $urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
		end
	end

	initial begin : sender
		clock_req_t rq, prev;
		int cur_h, cur_m, sel, gap;
		add_row(CMD_TICK, 0, 0, 3, {4'd0, 11'h000, 11'h7E0}, {4'd8, 11'h7E0, 11'h7E0},
			{4'd9, 11'h7E0, 11'h7E0});
		add_row(CMD_TICK, 0, 1, 0);     // rounds to the minute already shown
		add_row(CMD_TICK, 0, 2, 0);
		add_row(CMD_TICK, 0, 3);
		add_row(CMD_TICK, 13, 30);
		add_row(CMD_TICK, 23, 33);
		add_row(CMD_TICK, 31, 63);      // minute past 59 wraps and advances the hour
		add_row(CMD_TICK, 24, 58);
		add_row(CMD_TICK, 11, 57);
		add_row(CMD_TICK, 12, 60);
		add_row(CMD_REDRAW, 31, 63);
		add_row(CMD_TICK, 0, 0, 3, {4'd0, 11'h000, 11'h7E0}, {4'd8, 11'h7E0, 11'h7E0},
			{4'd9, 11'h7E0, 11'h7E0});
		add_row(CMD_REDRAW, 0, 0);
		add_row(CMD_REDRAW, 5, 17);
		add_row(CMD_TICK, 1, 10);
		add_row(CMD_TICK, 2, 15);
		add_row(CMD_TICK, 3, 20);
		add_row(CMD_TICK, 4, 25);
		add_row(CMD_TICK, 5, 40);
		add_row(CMD_TICK, 6, 45);
		add_row(CMD_TICK, 7, 50);
		add_row(CMD_TICK, 8, 5);
		add_row(CMD_TICK, 9, 35);
		add_row(CMD_TICK, 10, 55);
		add_row(CMD_TICK, 22, 44);

		show_banner();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i], ($urandom_range(0, 2) == 0) ? pick_gap() : 0);

		cur_h = $urandom_range(0, 23);
		cur_m = $urandom_range(0, 59);
		prev = directed[directed.size() - 1];
		hold_req = 1'b1;
		for (int k = 0; k < RANDOM_REQS; k++) begin
			rq.n_known = -1;
			rq.known = '0;
			rq.cmd = CMD_TICK;
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				rq.cmd = CMD_REDRAW;
				rq.hour = HOUR_W'($urandom_range(0, 31));
				rq.minute = MIN_W'($urandom_range(0, 63));
			end else if (sel < 15) begin
				rq.hour = prev.hour;
				rq.minute = prev.minute;
			end else if (sel < 40) begin
				rq.hour = HOUR_W'($urandom_range(0, 31));
				rq.minute = MIN_W'($urandom_range(0, 63));
			end else begin
				// advance a running clock by a few minutes
				cur_m += $urandom_range(1, 9);
				if (cur_m >= 60) begin
					cur_m -= 60;
					cur_h = (cur_h + 1) % 24;
				end
				rq.hour = HOUR_W'(cur_h);
				rq.minute = MIN_W'(cur_m);
			end
			gap = 0;
			if ((k / 64) % 2 == 1 && $urandom_range(0, 2) == 0)
				gap = pick_gap();
			send_request(rq, gap);
			prev = rq;
			if (k == RANDOM_REQS / 2) begin
				// drain the block before going on
				s_tvalid <= 1'b0;
				while (rows_due.size() != 0)
					@(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_word_clock_matrix_update OK");
		else
			$display("tb_word_clock_matrix_update NOT OK");
		$finish;
	end

endmodule
